FILE: design/pcx_pkg.sv
package pcx_pkg;

  localparam logic [1:0] ACT_PALETTE = 2'd0;
  localparam logic [1:0] ACT_DATA    = 2'd1;
  localparam logic [1:0] ACT_FRAME   = 2'd2;

  localparam logic [7:0] RUN_MARK   = 8'hC0;
  localparam logic [5:0] COUNT_MASK = 6'h3F;
  localparam logic [7:0] ALPHA_FULL = 8'd255;

  localparam int unsigned COL_W = 9;
  localparam int unsigned ROW_W = 8;

  localparam logic CFG_LAST_COLUMN = 1'b0;
  localparam logic CFG_LAST_ROW    = 1'b1;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             row_end;
    logic             frame_end;
    logic             frame_done;
  } raster_status_t;

endpackage

FILE: design/pcx_ram.sv
module pcx_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/pcx_raster.sv
module pcx_raster
  import pcx_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             step,
  input  logic [COL_W-1:0] last_col,
  input  logic [ROW_W-1:0] last_row,
  output raster_status_t   status
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             done_r, done_nxt;
  logic             row_end, frame_end;

  assign row_end   = (col_r >= last_col);
  assign frame_end = row_end && (row_r >= last_row);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    done_nxt = done_r;
    if (clear) begin
      col_nxt  = '0;
      row_nxt  = '0;
      done_nxt = 1'b0;
    end else if (step) begin
      if (row_end) begin
        col_nxt = '0;
        if (frame_end) begin
          done_nxt = 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      done_r <= 1'b1;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      done_r <= done_nxt;
    end
  end

  assign status.col        = col_r;
  assign status.row        = row_r;
  assign status.row_end    = row_end;
  assign status.frame_end  = frame_end;
  assign status.frame_done = done_r;

endmodule

FILE: design/pcx_rle_palette_decoder.sv
// Decodes an 8-bit PCX run-length stream into RGBA pixels with their x/y
// position. Input beats carry the action in in_tuser: a palette write, a
// compressed byte, or a start of frame. Palette writes, start-of-frame beats,
// run-count bytes and ignored bytes emit nothing. A pixel byte emits one pixel,
// or up to 63 after a run-count byte (none for zero), ending early at a row end;
// the single raster stepper walks one position per cycle while the output is
// not stalled, and no input is taken during a run. The palette is a 256 x 24
// RAM, undefined until written. out_tlast marks the last pixel of the frame,
// out_tuser the last pixel caused by one input byte. Configure last_column /
// last_row only while idle.
module pcx_rle_palette_decoder
  import pcx_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // data_byte, palette_index, palette_color
  input  logic [1:0]  in_tuser,  // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata, // red, green, blue, alpha, pixel_x, pixel_y, zero pad
  output logic        out_tuser, // run_last
  output logic        out_tlast, // frame_last
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wr_data
);

  localparam int unsigned COL_LIM_I = (MAX_WIDTH - 1 > 511) ? 511 : MAX_WIDTH - 1;
  localparam int unsigned ROW_LIM_I = (MAX_HEIGHT - 1 > 255) ? 255 : MAX_HEIGHT - 1;
  localparam logic [COL_W-1:0] COL_LIM = COL_LIM_I[COL_W-1:0];
  localparam logic [ROW_W-1:0] ROW_LIM = ROW_LIM_I[ROW_W-1:0];

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  logic [COL_W-1:0] last_col_r;
  logic [ROW_W-1:0] last_row_r;
  logic [COL_W-1:0] eff_col;
  logic [ROW_W-1:0] eff_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= 9'd319;
      last_row_r <= 8'd199;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LAST_COLUMN: last_col_r <= cfg_wr_data;
        CFG_LAST_ROW:    last_row_r <= cfg_wr_data[ROW_W-1:0];
        default:         last_col_r <= last_col_r;
      endcase
    end
  end

  assign eff_col = (last_col_r < COL_LIM) ? last_col_r : COL_LIM;
  assign eff_row = (last_row_r < ROW_LIM) ? last_row_r : ROW_LIM;

  logic [7:0]  in_byte;
  logic [7:0]  in_pidx;
  logic [23:0] in_color;
  assign in_byte  = in_tdata[7:0];
  assign in_pidx  = in_tdata[15:8];
  assign in_color = in_tdata[39:16];

  state_t         state_r, state_nxt;
  logic           pend_r, pend_nxt;
  logic [5:0]     pend_cnt_r, pend_cnt_nxt;
  logic [5:0]     remain_r, remain_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     red_r, green_r, blue_r;
  logic [COL_W-1:0] x_r;
  logic [ROW_W-1:0] y_r;
  logic           run_last_r, frame_last_r;

  logic           accept, fire, run_last;
  logic           pal_wr, pal_rd, sof;
  logic [23:0]    pal_rgb;
  raster_status_t rs;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign fire      = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign run_last  = (remain_r == 6'd1) || rs.row_end;
  assign pal_wr    = accept && (in_tuser == ACT_PALETTE);
  assign sof       = accept && (in_tuser == ACT_FRAME);

  pcx_ram #(
    .WIDTH(24),
    .DEPTH(256)
  ) u_palette (
    .clk    (clk),
    .wr_en  (pal_wr),
    .wr_addr(in_pidx),
    .wr_data(in_color),
    .rd_en  (pal_rd),
    .rd_addr(in_byte),
    .rd_data(pal_rgb)
  );

  pcx_raster u_raster (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (sof),
    .step    (fire),
    .last_col(eff_col),
    .last_row(eff_row),
    .status  (rs)
  );

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    pend_cnt_nxt  = pend_cnt_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r;
    pal_rd        = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == ACT_FRAME) begin
            pend_nxt     = 1'b0;
            pend_cnt_nxt = '0;
          end else if (in_tuser == ACT_DATA && !rs.frame_done) begin
            priority if (pend_r) begin
              pend_nxt     = 1'b0;
              pend_cnt_nxt = '0;
              if (pend_cnt_r != '0) begin
                pal_rd     = 1'b1;
                remain_nxt = pend_cnt_r;
                state_nxt  = ST_EMIT;
              end
            end else if ((in_byte & RUN_MARK) == RUN_MARK) begin
              pend_nxt     = 1'b1;
              pend_cnt_nxt = in_byte[5:0] & COUNT_MASK;
            end else begin
              pal_rd     = 1'b1;
              remain_nxt = 6'd1;
              state_nxt  = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (fire) begin
          out_valid_nxt = 1'b1;
          remain_nxt    = remain_r - 1'b1;
          if (run_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      red_r        <= pal_rgb[23:16];
      green_r      <= pal_rgb[15:8];
      blue_r       <= pal_rgb[7:0];
      x_r          <= rs.col;
      y_r          <= rs.row;
      run_last_r   <= run_last;
      frame_last_r <= rs.frame_end;
    end
    remain_r <= remain_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, y_r, x_r, ALPHA_FULL, blue_r, green_r, red_r};
  assign out_tuser  = run_last_r;
  assign out_tlast  = frame_last_r;

endmodule
